[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define AST_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define AST_IMPL(lbl, clk, rst, ante, cons)
`define AST_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[hdl/bfss_pkg.sv]
// ---------------------------------------------------------------------------
// bfss_pkg
// Types, constants and saturating helpers of the string search core.
// ---------------------------------------------------------------------------
package bfss_pkg;

   localparam int CHAR_W       = 8;
   localparam int CSIZE_W      = 9;
   localparam int TLEN_W       = 8;
   localparam int TARGET_CHARS = 3;
   localparam int MATCH_W      = TARGET_CHARS * CHAR_W;
   localparam int ATT_W        = 25;
   localparam logic [ATT_W-1:0] ATT_CAP = '1;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LENS,
      ST_SCAN_ADDR,
      ST_SCAN_CMP,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                req_type;
      logic [CHAR_W-1:0]   entry_index;
      logic [CHAR_W-1:0]   entry_char;
      logic [MATCH_W-1:0]  target_chars;
      logic [TLEN_W-1:0]   target_length;
   } req_payload_type;

   typedef struct packed {
      logic                found;
      logic [MATCH_W-1:0]  match_chars;
      logic [1:0]          match_length;
      logic [ATT_W-1:0]    attempts;
   } rsp_payload_type;

   // Saturating multiply of a count by a charset size.
   function automatic logic [ATT_W-1:0] sat_mul(input logic [ATT_W-1:0]   a,
                                                input logic [CSIZE_W-1:0] b);
      logic [ATT_W+CSIZE_W-1:0] p;
      p = (ATT_W+CSIZE_W)'(a) * (ATT_W+CSIZE_W)'(b);
      return (p > (ATT_W+CSIZE_W)'(ATT_CAP)) ? ATT_CAP : p[ATT_W-1:0];
   endfunction

   // Saturating add of two counts.
   function automatic logic [ATT_W-1:0] sat_add(input logic [ATT_W-1:0] a,
                                                input logic [ATT_W-1:0] b);
      logic [ATT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ATT_W] ? ATT_CAP : s[ATT_W-1:0];
   endfunction

endpackage

[hdl/bfss_ram.sv]
// ---------------------------------------------------------------------------
// bfss_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bfss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/brute_force_string_search_core.sv]
// ---------------------------------------------------------------------------
// brute_force_string_search_core: a load item writes one charset entry; a
// search item sums the length powers, then scans the one-read charset RAM,
// reading one entry in ST_SCAN_ADDR and comparing it in ST_SCAN_CMP, for each
// target position in turn. Synchronous reset clears the sequencer, result
// valid and charset size; table undefined.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brute_force_string_search_core
   import bfss_pkg::*;
#(
   parameter int MAX_LEN       = 3,
   parameter int CHARSET_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  req_payload_type     req_payload,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_payload_type     rsp_payload,
   // charset size register
   input  logic                csr_wr_en,
   input  logic [CSIZE_W-1:0]  csr_wr_data
);

   localparam int AW = $clog2(CHARSET_DEPTH);
   localparam int SW = $clog2(MAX_LEN + 1);

   // Sequencer and control state
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CSIZE_W-1:0]    csize_ff;

   // Search datapath
   logic [CSIZE_W-1:0]    n_ff, n_in;
   logic [MATCH_W-1:0]    tchars_ff, tchars_in;
   logic [TLEN_W-1:0]     tlen_ff, tlen_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [SW-1:0]         pos_ff, pos_in;
   logic [CSIZE_W-1:0]    j_ff, j_in;
   logic [ATT_W-1:0]      pw_ff, pw_in;
   logic [ATT_W-1:0]      total_ff, total_in;
   logic [ATT_W-1:0]      before_ff, before_in;
   logic [ATT_W-1:0]      rank_ff, rank_in;
   logic [ATT_W-1:0]      att_ff, att_in;
   logic                  found_ff, found_in;
   rsp_payload_type       rsp_ff, rsp_in;

   // Shared multiplier and helpers
   logic [ATT_W-1:0]      mul_a;
   logic [ATT_W-1:0]      mul_p;
   logic [CHAR_W-1:0]     target_char;
   logic [MATCH_W-1:0]    match_mask;
   logic                  tlen_ok;
   logic                  req_beat;
   logic                  search_beat;
   logic                  rsp_free;
   logic                  ram_we;
   logic [CHAR_W-1:0]     ram_rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign search_beat = req_beat && (req_payload.req_type == REQ_SEARCH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The output register can take a new beat when empty or draining now.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Write the table on a load beat whose index lands inside the table.
   assign ram_we = req_beat && (req_payload.req_type == REQ_LOAD) &&
                   ({1'b0, req_payload.entry_index} < CSIZE_W'(CHARSET_DEPTH));

   bfss_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CHARSET_DEPTH)
   ) u_charset (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_payload.entry_index[AW-1:0]),
      .wr_data (req_payload.entry_char),
      .rd_addr (j_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // One multiplier serves both the length powers and the rank accumulation.
   assign mul_a = (state_ff == ST_LENS) ? pw_ff : rank_ff;
   assign mul_p = sat_mul(mul_a, n_ff);

   // Target character at the current position; positions past the field read 0.
   assign target_char = (8'(pos_ff) < 8'(TARGET_CHARS)) ?
                        CHAR_W'(tchars_ff >> {pos_ff, 3'b000}) : '0;

   assign tlen_ok = (n_ff != '0) && (tlen_ff != '0) && (tlen_ff <= TLEN_W'(MAX_LEN));

   assign match_mask = (tlen_ff >= TLEN_W'(TARGET_CHARS)) ? '1 :
                       ~({MATCH_W{1'b1}} << {tlen_ff, 3'b000});

   // State register and control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         csize_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csize_ff <= csr_wr_data;
         end
      end
   end

   // Datapath flops, no reset needed
   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      tchars_ff <= tchars_in;
      tlen_ff   <= tlen_in;
      step_ff   <= step_in;
      pos_ff    <= pos_in;
      j_ff      <= j_in;
      pw_ff     <= pw_in;
      total_ff  <= total_in;
      before_ff <= before_in;
      rank_ff   <= rank_in;
      att_ff    <= att_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      n_in         = n_ff;
      tchars_in    = tchars_ff;
      tlen_in      = tlen_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      j_in         = j_ff;
      pw_in        = pw_ff;
      total_in     = total_ff;
      before_in    = before_ff;
      rank_in      = rank_ff;
      att_in       = att_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Latch a search and clamp the charset size; loads stay here.
            if (search_beat) begin
               n_in      = (csize_ff > CSIZE_W'(CHARSET_DEPTH)) ?
                           CSIZE_W'(CHARSET_DEPTH) : csize_ff;
               tchars_in = req_payload.target_chars;
               tlen_in   = req_payload.target_length;
               step_in   = SW'(1);
               pw_in     = ATT_W'(1);
               total_in  = '0;
               before_in = '0;
               state_in  = ST_LENS;
            end
         end

         ST_LENS: begin
            // Accumulate n^i into the total, and into the count of
            // shorter candidates while i is below the target length.
            pw_in    = mul_p;
            total_in = sat_add(total_ff, mul_p);
            if (TLEN_W'(step_ff) < tlen_ff) begin
               before_in = sat_add(before_ff, mul_p);
            end
            if (step_ff == SW'(MAX_LEN)) begin
               pos_in  = '0;
               j_in    = '0;
               rank_in = '0;
               if (tlen_ok) begin
                  state_in = ST_SCAN_ADDR;
               end else begin
                  found_in = 1'b0;
                  state_in = ST_FINISH;
               end
            end else begin
               step_in = step_ff + SW'(1);
            end
         end

         ST_SCAN_ADDR: begin
            // RAM read of entry j is in flight.
            state_in = ST_SCAN_CMP;
         end

         ST_SCAN_CMP: begin
            if (ram_rd_data == target_char) begin
               // First hit wins; fold its index into the rank.
               rank_in = sat_add(mul_p, ATT_W'(j_ff));
               j_in    = '0;
               if (TLEN_W'(pos_ff) + TLEN_W'(1) == tlen_ff) begin
                  found_in = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  pos_in   = pos_ff + SW'(1);
                  state_in = ST_SCAN_ADDR;
               end
            end else if (j_ff + CSIZE_W'(1) == n_ff) begin
               found_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               j_in     = j_ff + CSIZE_W'(1);
               state_in = ST_SCAN_ADDR;
            end
         end

         ST_FINISH: begin
            att_in   = found_ff ? sat_add(sat_add(before_ff, rank_ff), ATT_W'(1))
                                : total_ff;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // Hold until the output register is free, then publish the beat.
            if (rsp_free) begin
               rsp_in.found        = found_ff;
               rsp_in.match_chars  = found_ff ? (tchars_ff & match_mask) : '0;
               rsp_in.match_length = found_ff ? tlen_ff[1:0] : 2'd0;
               rsp_in.attempts     = att_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Checks
   `AST_NEXT(a_done_loads, clock, reset, (state_ff == ST_DONE) && rsp_free, rsp_valid_ff)
   `AST_IMPL(a_found_counts, clock, reset, rsp_valid_ff && rsp_ff.found, rsp_ff.attempts != '0)
   `AST_IMPL(a_scan_bound, clock, reset, state_ff == ST_SCAN_CMP, j_ff < n_ff)
   `AST_NEXT(a_search_starts, clock, reset, search_beat, state_ff == ST_LENS)

endmodule

[bench/brute_force_string_search_core_tb.sv]
// ---------------------------------------------------------------------------
// brute_force_string_search_core_tb
// Self-checking bench for the string search core. It loads charset tables,
// sweeps the charset size register and sends search beats, while a local
// predictor works out found, match and attempt count for every search.
// Both handshakes stall at random. Each response beat is checked field by
// field against the oldest prediction.
// ---------------------------------------------------------------------------
module brute_force_string_search_core_tb;
   import bfss_pkg::*;

   localparam int DEPTH       = 256;
   localparam int MAX_CHARS   = 3;
   localparam int HOLDOFF     = 20;       // cycles after the last response
   localparam int CYCLE_LIMIT = 800000;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en   = 1'b0;
   logic [CSIZE_W-1:0] csr_wr_data = '0;

   // Local copy of the block's charset table and size register.
   logic [CHAR_W-1:0] charset_copy [DEPTH];
   bit                loaded       [DEPTH];
   int unsigned       charset_len = 0;

   rsp_payload_type   pending_results [$];
   bit                steady = 1'b0;     // no idling on either side when set
   int                errors = 0;
   int                n_loads = 0;
   int                n_searches = 0;
   int                n_found = 0;
   int unsigned       cycles = 0;

   brute_force_string_search_core #(
      .MAX_LEN       (MAX_CHARS),
      .CHARSET_DEPTH (DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Bound the run; a hang anywhere ends up here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("brute_force_string_search_core_tb failed");
         $finish;
      end
   end

   // Stall the response side at random, about 12 percent of the time, unless steady.
   always @(negedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 12);
   end

   // Work out the response of one search beat from the local table copy.
   // The attempt count is the rank of the match in the enumeration: all
   // shorter candidates, then odometer order with the last position fastest.
   function automatic rsp_payload_type search_outcome(input req_payload_type beat);
      rsp_payload_type   r;
      int unsigned       n;
      int unsigned       tlen;
      int unsigned       pos [MAX_CHARS];
      longint unsigned   pw;
      longint unsigned   total;
      longint unsigned   shorter;
      longint unsigned   rank;
      longint unsigned   att;
      logic [CHAR_W-1:0] c;
      bit                hit;
      int                i;
      int unsigned       j;
      r       = '0;
      n       = (charset_len > DEPTH) ? DEPTH : charset_len;
      tlen    = 32'(beat.target_length);
      pw      = 1;
      total   = 0;
      shorter = 0;
      for (i = 1; i <= MAX_CHARS; i++) begin
         pw = pw * n;
         if (i < tlen) shorter += pw;
         total += pw;
      end
      hit = (n != 0) && (tlen >= 1) && (tlen <= MAX_CHARS);
      for (i = 0; hit && i < tlen; i++) begin
         // first occurrence of a duplicate byte wins
         c = beat.target_chars[CHAR_W*i +: CHAR_W];
         j = 0;
         while (j < n && charset_copy[j] != c) j++;
         if (j == n) hit = 1'b0;
         else pos[i] = j;
      end
      if (hit) begin
         rank = 0;
         for (i = 0; i < tlen; i++) begin
            rank = rank * n + pos[i];
            r.match_chars[CHAR_W*i +: CHAR_W] = beat.target_chars[CHAR_W*i +: CHAR_W];
         end
         att            = shorter + rank + 1;
         r.found        = 1'b1;
         r.match_length = tlen[1:0];
      end else begin
         att = total;
      end
      if (att > longint'(ATT_CAP)) att = longint'(ATT_CAP);
      r.attempts = att[ATT_W-1:0];
      return r;
   endfunction

   // Send one beat; enter and leave at a falling edge. Valid stays high
   // after acceptance so that a following beat can go out back to back.
   task automatic send_beat(input req_payload_type beat);
      rsp_payload_type want;
      if (!steady && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < 12) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (beat.req_type == REQ_LOAD) begin
         charset_copy[beat.entry_index] = beat.entry_char;
         loaded[beat.entry_index]       = 1'b1;
         n_loads++;
      end else begin
         want = search_outcome(beat);
         if (want.found) n_found++;
         pending_results.push_back(want);
         n_searches++;
      end
   endtask

   task automatic load_entry(input int unsigned idx, input int unsigned ch);
      req_payload_type beat;
      beat.req_type      = REQ_LOAD;
      beat.entry_index   = idx[CHAR_W-1:0];
      beat.entry_char    = ch[CHAR_W-1:0];
      // fill the search fields with noise: the load must ignore them
      beat.target_chars  = MATCH_W'($urandom());
      beat.target_length = TLEN_W'($urandom());
      send_beat(beat);
   endtask

   task automatic search(input logic [MATCH_W-1:0] chars, input int unsigned len);
      req_payload_type beat;
      beat.req_type      = REQ_SEARCH;
      beat.entry_index   = CHAR_W'($urandom());
      beat.entry_char    = CHAR_W'($urandom());
      beat.target_chars  = chars;
      beat.target_length = len[TLEN_W-1:0];
      send_beat(beat);
   endtask

   // Drop valid, wait for every outstanding response, then let trailing
   // load beats settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
      repeat (HOLDOFF) @(negedge clock);
   endtask

   // Write the charset size once the block is idle. Fill any table entry
   // below the new size first, so a search never reads an unwritten entry.
   task automatic set_size(input int unsigned value);
      int unsigned n;
      int unsigned idx;
      n = (value > DEPTH) ? DEPTH : value;
      for (idx = 0; idx < n; idx++) begin
         if (!loaded[idx]) load_entry(idx, $urandom_range(255));
      end
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[CSIZE_W-1:0];
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      charset_len  = value;
   endtask

   // Build a target out of bytes present in the active part of the table.
   function automatic logic [MATCH_W-1:0] pick_target(input int unsigned len);
      logic [MATCH_W-1:0] chars;
      int unsigned        n;
      int                 i;
      n     = (charset_len > DEPTH) ? DEPTH : charset_len;
      chars = MATCH_W'($urandom());
      for (i = 0; i < len; i++) begin
         chars[CHAR_W*i +: CHAR_W] = charset_copy[$urandom_range(n - 1)];
      end
      return chars;
   endfunction

   // Size 0: nothing to enumerate, whatever the target.
   task automatic test_empty_charset();
      set_size(0);
      search(24'h000000, 1);
      search(24'hFFFFFF, 3);
      search(24'h123456, 0);
      search(24'hABCDEF, 2);
   endtask

   // Four entries: hits at each length, misses and the bad lengths 0, 4 and 255.
   task automatic test_small_charset();
      load_entry(0, 8'h61);   // 'a'
      load_entry(1, 8'h62);   // 'b'
      load_entry(2, 8'h63);   // 'c'
      load_entry(3, 8'h64);   // 'd'
      set_size(4);
      search(24'hFFFF61, 1);  // "a" with junk above the length: masked off
      search(24'h000064, 1);  // "d"
      search(24'h006261, 2);  // "ab"
      search(24'h646464, 3);  // "ddd": the last candidate
      search(24'h000078, 1);  // "x": miss, every candidate tried
      search(24'h006178, 2);  // miss in the first position only
      search(24'h616161, 0);
      search(24'h616161, 4);
      search(24'h616161, 255);
   endtask

   // Duplicate bytes: the lower index is reached first.
   task automatic test_duplicates();
      load_entry(2, 8'h61);   // table reads a, b, a, d
      search(24'h000061, 1);
      search(24'h616161, 3);
      search(24'h000063, 1);  // 'c' is gone now
   endtask

   // Full table of distinct bytes, then the clamp of an oversized size.
   task automatic test_full_table();
      int unsigned idx;
      for (idx = 0; idx < DEPTH; idx++) load_entry(idx, idx ^ 8'h5A);
      set_size(256);
      search(24'hA5A5A5, 3);  // last entry three times: the deepest search
      search(24'h00005A, 1);  // first entry
      search(24'h000000, 0);
      set_size(511);          // all size bits set, clamps to the depth
      search(24'hA55A5A, 3);
      search(24'h0000FF, 2);
      set_size(1);
      search(24'h5A5A5A, 3);
      search(24'h000000, 1);
      set_size(0);
      search(24'h5A5A5A, 3);
   endtask

   // Random phases over several sizes: mostly targets built from the table,
   // some loads, some noise targets of any length.
   task automatic test_random();
      int          p;
      int          k;
      int unsigned r;
      int unsigned len;
      int unsigned value;
      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin
               value = $urandom_range(1, 4);
            end
            1: begin
               value = $urandom_range(5, 40);
            end
            2: begin
               value = 256;
            end
            default: begin
               value = $urandom_range(257, 511);
            end
         endcase
         set_size(value);
         // hold both sides busy through one whole phase
         steady = (p == 1);
         for (k = 0; k < 25; k++) begin
            r = $urandom_range(99);
            if (r < 10) begin
               load_entry($urandom_range(DEPTH - 1), $urandom_range(255));
            end else if (r < 75) begin
               len = $urandom_range(1, MAX_CHARS);
               search(pick_target(len), len);
            end else if (r < 88) begin
               search(MATCH_W'($urandom()), $urandom_range(255));
            end else begin
               search(MATCH_W'($urandom()), $urandom_range(1, MAX_CHARS));
            end
         end
         steady = 1'b0;
      end
   endtask

   // Compare each response beat with the oldest prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response beat with no search outstanding");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_payload.found);
               errors++;
            end
            if (rsp_payload.match_chars !== want.match_chars) begin
               $error("match_chars: expected %h, got %h",
                      want.match_chars, rsp_payload.match_chars);
               errors++;
            end
            if (rsp_payload.match_length !== want.match_length) begin
               $error("match_length: expected %0d, got %0d",
                      want.match_length, rsp_payload.match_length);
               errors++;
            end
            if (rsp_payload.attempts !== want.attempts) begin
               $error("attempts: expected %0d, got %0d",
                      want.attempts, rsp_payload.attempts);
               errors++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) loaded[i] = 1'b0;
      // hold reset, then release it at a falling edge
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_charset();
      test_small_charset();
      test_duplicates();
      test_full_table();
      test_random();

      drain();
      $display("Ran %0d charset loads and %0d searches, %0d of them hits,",
               n_loads, n_searches, n_found);
      $display("over charset sizes from 0 up to 511 with random stalls on both sides.");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("brute_force_string_search_core_tb passed");
      end else begin
         $display("brute_force_string_search_core_tb failed");
      end
      $finish;
   end

endmodule
